@@ hdl/lans_pkg.sv @@
// ============================================================================
// Locality-aware node selector package
// Shared widths, register indexes, command codes, the record that travels
// from the front stage through the remainder pipeline, and bit helpers.
// ============================================================================
package lans_pkg;

    // Field widths
    localparam int NODE_W = 5;
    localparam int CNT_W  = 6;
    localparam int MASK_W = 32;
    localparam int RND_W  = 31;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 2;

    // Remainder pipeline: bits of the random word retired per stage
    localparam int MOD_STEP   = 4;
    localparam int MOD_STAGES = (RND_W + MOD_STEP - 1) / MOD_STEP;
    localparam int DIVP_W     = MOD_STAGES * MOD_STEP;

    // Clock edges from an accepted transaction to its result strobe
    localparam int LATENCY = MOD_STAGES + 2;

    // Command codes
    localparam logic CMD_INITIAL = 1'b0;
    localparam logic CMD_NEXT    = 1'b1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_NODE_COUNT   = 2'd0;
    localparam logic [IDX_W-1:0] REG_LOCAL_DC     = 2'd1;
    localparam logic [IDX_W-1:0] REG_SELF_PRESENT = 2'd2;
    localparam logic [IDX_W-1:0] REG_SELF_INDEX   = 2'd3;

    // Configuration as seen by the front stage
    typedef struct packed {
        logic [CNT_W-1:0]  node_count;
        logic [MASK_W-1:0] local_dc_mask;
        logic              self_present;
        logic [NODE_W-1:0] self_index;
    } lans_cfg_t;

    // Classified request carried to the back stage
    typedef struct packed {
        logic              direct;      // selection already decided up front
        logic              found;
        logic [NODE_W-1:0] pick;
        logic [CNT_W-1:0]  up_count;
        logic [CNT_W-1:0]  local_count;
        logic [MASK_W-1:0] sel_mask;    // candidates for the ranked pick
    } lans_item_t;

    // Population count as a balanced adder tree.
    function automatic logic [CNT_W-1:0] popcount32(input logic [MASK_W-1:0] v);
        logic [1:0] s1 [16];
        logic [2:0] s2 [8];
        logic [3:0] s3 [4];
        logic [4:0] s4 [2];
        for (int i = 0; i < 16; i++)
            s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        for (int i = 0; i < 8; i++)
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        for (int i = 0; i < 4; i++)
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        for (int i = 0; i < 2; i++)
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        return {1'b0, s4[0]} + {1'b0, s4[1]};
    endfunction

    // Index of the lowest set bit, zero when none is set.
    function automatic logic [NODE_W-1:0] lowest_set(input logic [MASK_W-1:0] v);
        logic [NODE_W-1:0] idx;
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
            if (v[i])
                idx = NODE_W'(i);
        return idx;
    endfunction

endpackage

@@ hdl/lans_front.sv @@
// ============================================================================
// Locality-aware node selector front stage
// Accepts a request, counts up and local members, and settles the self pick
// and the circular next-node search. Initial picks that need a random rank
// leave with their candidate mask and divisor for the remainder pipeline.
// ============================================================================
module lans_front
    import lans_pkg::*;
#(
    parameter int MAX_NODES = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lans_cfg_t         cfg,
    input  logic              cmd,
    input  logic              ignore_local,
    input  logic [MASK_W-1:0] up_mask,
    input  logic [NODE_W-1:0] current_node,
    input  logic              current_known,
    input  logic [RND_W-1:0]  random_value,
    output logic              out_valid,
    output lans_item_t        out_item,
    output logic [RND_W-1:0]  out_dividend,
    output logic [CNT_W-1:0]  out_divisor
);

    localparam logic [CNT_W:0] MAX_N = (CNT_W + 1)'(MAX_NODES);

    logic [CNT_W-1:0]  n_eff;
    logic [MASK_W-1:0] member;
    logic [MASK_W-1:0] up_eff;

    // Initial mode
    logic [MASK_W-1:0] loc_init;
    logic [CNT_W-1:0]  ups_init;
    logic [CNT_W-1:0]  locs_init;
    logic              use_local;
    logic              self_up;

    // Next mode
    logic [NODE_W-1:0] start_idx;
    logic [MASK_W-1:0] above;
    logic [MASK_W-1:0] cand;
    logic [MASK_W-1:0] cand_loc;
    logic [NODE_W-1:0] first_any;
    logic [NODE_W-1:0] first_loc;
    logic              take_local;

    logic              valid_reg;
    lans_item_t        item_reg;
    lans_item_t        item_next;
    logic [RND_W-1:0]  dividend_reg;
    logic [CNT_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]  divisor_next;

    // Members beyond the clamped count, or beyond the mask, are never up.
    always_comb
    begin
        n_eff = ({1'b0, cfg.node_count} > MAX_N) ? MAX_N[CNT_W-1:0] : cfg.node_count;
        for (int i = 0; i < MASK_W; i++)
            member[i] = (CNT_W'(i) < n_eff);
        up_eff = up_mask & member;
    end

    // Initial mode: counts, self check and the candidate set for the rank.
    always_comb
    begin
        loc_init  = ignore_local ? '0 : (up_eff & cfg.local_dc_mask);
        ups_init  = popcount32(up_eff);
        locs_init = popcount32(loc_init);
        use_local = (locs_init != '0);
        self_up   = cfg.self_present && up_eff[cfg.self_index];
    end

    // Next mode: first candidate above the start, else lowest; local first.
    always_comb
    begin
        start_idx = (current_known && ({1'b0, current_node} < n_eff)) ? current_node : '0;
        for (int i = 0; i < MASK_W; i++)
            above[i] = (NODE_W'(i) > start_idx);
        cand       = up_eff & ~(MASK_W'(1) << start_idx);
        cand_loc   = cand & cfg.local_dc_mask;
        first_any  = ((cand & above) != '0) ? lowest_set(cand & above) : lowest_set(cand);
        first_loc  = ((cand_loc & above) != '0) ? lowest_set(cand_loc & above)
                                                : lowest_set(cand_loc);
        take_local = !ignore_local && (cand_loc != '0);
    end

    // Classification of the transaction.
    always_comb
    begin
        item_next    = '0;
        divisor_next = '0;
        unique case (cmd)
            CMD_NEXT:
            begin
                item_next.direct      = 1'b1;
                item_next.found       = (cand != '0);
                item_next.pick        = take_local ? first_loc :
                                        ((cand != '0) ? first_any : '0);
                item_next.up_count    = popcount32(cand);
                item_next.local_count = popcount32(cand_loc);
            end
            CMD_INITIAL:
            begin
                item_next.direct      = self_up;
                item_next.found       = self_up || (ups_init != '0);
                item_next.pick        = self_up ? cfg.self_index : '0;
                item_next.up_count    = ups_init;
                item_next.local_count = locs_init;
                item_next.sel_mask    = use_local ? loc_init : up_eff;
                divisor_next          = use_local ? locs_init : ups_init;
            end
        endcase
    end

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        dividend_reg <= random_value;
        divisor_reg  <= divisor_next;
    end

    assign out_valid    = valid_reg;
    assign out_item     = item_reg;
    assign out_dividend = dividend_reg;
    assign out_divisor  = divisor_reg;

endmodule

@@ hdl/lans_mod.sv @@
// ============================================================================
// Locality-aware node selector remainder pipeline
// Reduces the random word modulo the candidate count, four dividend bits
// per stage, and carries the classified request alongside. It forms the
// queue between the front and back stages.
// ============================================================================
module lans_mod
    import lans_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  lans_item_t       in_item,
    input  logic [RND_W-1:0] in_dividend,
    input  logic [CNT_W-1:0] in_divisor,
    output logic             out_valid,
    output lans_item_t       out_item,
    output logic [CNT_W-1:0] out_rem
);

    logic              valid_reg    [MOD_STAGES];
    lans_item_t        item_reg     [MOD_STAGES];
    logic [DIVP_W-1:0] dividend_reg [MOD_STAGES];
    logic [CNT_W-1:0]  divisor_reg  [MOD_STAGES];
    logic [CNT_W-1:0]  rem_reg      [MOD_STAGES];

    logic              valid_src    [MOD_STAGES];
    lans_item_t        item_src     [MOD_STAGES];
    logic [DIVP_W-1:0] dividend_src [MOD_STAGES];
    logic [CNT_W-1:0]  divisor_src  [MOD_STAGES];
    logic [CNT_W-1:0]  rem_src      [MOD_STAGES];
    logic [DIVP_W-1:0] dividend_next[MOD_STAGES];
    logic [CNT_W-1:0]  rem_next     [MOD_STAGES];

    // Restoring remainder steps, most significant dividend bit first.
    function automatic logic [CNT_W-1:0] mod_step(
        input logic [CNT_W-1:0]    r,
        input logic [MOD_STEP-1:0] b,
        input logic [CNT_W-1:0]    d
    );
        logic [CNT_W:0]   t;
        logic [CNT_W-1:0] acc;
        acc = r;
        for (int j = MOD_STEP - 1; j >= 0; j--)
        begin
            t = {acc, b[j]};
            if (t >= {1'b0, d})
                t = t - {1'b0, d};
            acc = t[CNT_W-1:0];
        end
        return acc;
    endfunction

    // Stage inputs and one remainder step per stage.
    always_comb
    begin
        for (int s = 0; s < MOD_STAGES; s++)
        begin
            if (s == 0)
            begin
                valid_src[s]    = in_valid;
                item_src[s]     = in_item;
                dividend_src[s] = DIVP_W'(in_dividend);
                divisor_src[s]  = in_divisor;
                rem_src[s]      = '0;
            end
            else
            begin
                valid_src[s]    = valid_reg[s-1];
                item_src[s]     = item_reg[s-1];
                dividend_src[s] = dividend_reg[s-1];
                divisor_src[s]  = divisor_reg[s-1];
                rem_src[s]      = rem_reg[s-1];
            end
            rem_next[s] = mod_step(rem_src[s],
                                   dividend_src[s][DIVP_W-1 -: MOD_STEP],
                                   divisor_src[s]);
            dividend_next[s] = dividend_src[s] << MOD_STEP;
        end
    end

    // Stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MOD_STAGES; s++)
                valid_reg[s] <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < MOD_STAGES; s++)
                valid_reg[s] <= valid_src[s];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < MOD_STAGES; s++)
        begin
            item_reg[s]     <= item_src[s];
            dividend_reg[s] <= dividend_next[s];
            divisor_reg[s]  <= divisor_src[s];
            rem_reg[s]      <= rem_next[s];
        end
    end

    assign out_valid = valid_reg[MOD_STAGES-1];
    assign out_item  = item_reg[MOD_STAGES-1];
    assign out_rem   = rem_reg[MOD_STAGES-1];

endmodule

@@ hdl/lans_back.sv @@
// ============================================================================
// Locality-aware node selector back stage
// Finds the candidate of the computed rank for random picks, takes decided
// picks as they are, and registers the result for one strobe cycle.
// ============================================================================
module lans_back
    import lans_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lans_item_t        in_item,
    input  logic [CNT_W-1:0]  in_rank,
    output logic              done,
    output logic              found,
    output logic [NODE_W-1:0] node_index,
    output logic [CNT_W-1:0]  up_count,
    output logic [CNT_W-1:0]  local_count
);

    logic [CNT_W-1:0]  prefix [MASK_W];
    logic [NODE_W-1:0] ranked;
    logic              found_next;
    logic [NODE_W-1:0] node_index_next;

    logic              done_reg;
    logic              found_reg;
    logic [NODE_W-1:0] node_index_reg;
    logic [CNT_W-1:0]  up_count_reg;
    logic [CNT_W-1:0]  local_count_reg;

    // Each candidate's rank is the number of candidates below it.
    always_comb
    begin
        ranked = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            prefix[i] = popcount32(in_item.sel_mask & ((MASK_W'(1) << i) - MASK_W'(1)));
            if (in_item.sel_mask[i] && (prefix[i] == in_rank))
                ranked = NODE_W'(i);
        end
    end

    // Decided picks pass; otherwise the ranked candidate is taken.
    always_comb
    begin
        found_next      = in_item.found;
        node_index_next = in_item.direct ? in_item.pick : (in_item.found ? ranked : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg       <= found_next;
        node_index_reg  <= node_index_next;
        up_count_reg    <= in_item.up_count;
        local_count_reg <= in_item.local_count;
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign node_index  = node_index_reg;
    assign up_count    = up_count_reg;
    assign local_count = local_count_reg;

endmodule

@@ hdl/locality_aware_node_selector.sv @@
// ============================================================================
// Locality-aware node selector
// Picks a member node for a request: this host when it is up, a random up
// node of the same datacenter or of the whole cluster, or the next usable
// node on the ring after the current one.
// ============================================================================
//
//  Channel   Handshake           Payload
//  -------   -----------------   ---------------------------------------------
//  request   start, busy         cmd, ignore_local, up_mask, current_node,
//                                current_known, random_value
//  result    done (strobe)       found, node_index, up_count, local_count
//  config    cfg_we              cfg_index, cfg_data
//
//  One transaction is accepted per clock; busy stays low.
//  Between its request and its result, each transaction passes one front
//  stage, eight remainder stages of four bits each, and the output register.
//  The remainder pipeline sets this depth.
//  Reset clears the pipeline valid bits and loads the register defaults.
//  Results are strobed for one cycle and cannot be held off.
//
module locality_aware_node_selector
    import lans_pkg::*;
#(
    parameter int MAX_NODES = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cmd,
    input  logic              ignore_local,
    input  logic [MASK_W-1:0] up_mask,
    input  logic [NODE_W-1:0] current_node,
    input  logic              current_known,
    input  logic [RND_W-1:0]  random_value,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    output logic              done,
    output logic              found,
    output logic [NODE_W-1:0] node_index,
    output logic [CNT_W-1:0]  up_count,
    output logic [CNT_W-1:0]  local_count
);

    logic [CNT_W-1:0]  node_count_reg;
    logic [MASK_W-1:0] local_dc_mask_reg;
    logic              self_present_reg;
    logic [NODE_W-1:0] self_index_reg;
    lans_cfg_t         cfg;

    logic              accept;
    logic              front_valid;
    lans_item_t        front_item;
    logic [RND_W-1:0]  front_dividend;
    logic [CNT_W-1:0]  front_divisor;
    logic              back_valid;
    lans_item_t        back_item;
    logic [CNT_W-1:0]  back_rank;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg    <= CNT_W'(1);
            local_dc_mask_reg <= '0;
            self_present_reg  <= 1'b0;
            self_index_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NODE_COUNT:   node_count_reg    <= cfg_data[CNT_W-1:0];
                REG_LOCAL_DC:     local_dc_mask_reg <= cfg_data[MASK_W-1:0];
                REG_SELF_PRESENT: self_present_reg  <= cfg_data[0];
                REG_SELF_INDEX:   self_index_reg    <= cfg_data[NODE_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        cfg.node_count    = node_count_reg;
        cfg.local_dc_mask = local_dc_mask_reg;
        cfg.self_present  = self_present_reg;
        cfg.self_index    = self_index_reg;
    end

    // The pipeline never stalls, so every start is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    lans_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .cfg           (cfg),
        .cmd           (cmd),
        .ignore_local  (ignore_local),
        .up_mask       (up_mask),
        .current_node  (current_node),
        .current_known (current_known),
        .random_value  (random_value),
        .out_valid     (front_valid),
        .out_item      (front_item),
        .out_dividend  (front_dividend),
        .out_divisor   (front_divisor)
    );

    lans_mod u_mod (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (front_valid),
        .in_item     (front_item),
        .in_dividend (front_dividend),
        .in_divisor  (front_divisor),
        .out_valid   (back_valid),
        .out_item    (back_item),
        .out_rem     (back_rank)
    );

    lans_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (back_valid),
        .in_item     (back_item),
        .in_rank     (back_rank),
        .done        (done),
        .found       (found),
        .node_index  (node_index),
        .up_count    (up_count),
        .local_count (local_count)
    );

endmodule

@@ hdl/lans_checker.sv @@
// ============================================================================
// Locality-aware node selector checker
// Watches the top-level ports for fixed latency and consistent results.
// ============================================================================
module lans_checker
    import lans_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic              found,
    input logic [NODE_W-1:0] node_index,
    input logic [CNT_W-1:0]  up_count,
    input logic [CNT_W-1:0]  local_count
);

    // Every accepted transaction produces a result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted transaction produced no result");

    // No result appears without a transaction accepted before it.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching transaction");

    // A failed selection reports node zero.
    a_empty_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (node_index == '0))
        else $error("node index set without a selection");

    // A selection needs an up node, and local nodes are a subset of up nodes.
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((local_count <= up_count) && (!found || (up_count != '0))))
        else $error("inconsistent counts in result");

endmodule

bind locality_aware_node_selector lans_checker u_lans_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .found       (found),
    .node_index  (node_index),
    .up_count    (up_count),
    .local_count (local_count)
);
